// ----- src/bmpdec_pkg.sv -----
// Shared types and constants for the BMP 24-bit pixel stream decoder.
// No dependencies; compiled before every other file of the block.
package bmpdec_pkg;

    // Largest image the decoder accepts; larger headers give a size error.
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;

    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 12;
    localparam int SCREEN_W    = 13;
    localparam int WORD_W      = 32;
    // Column and row counters must hold the maximum dimension itself.
    localparam int COL_CNT_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_CNT_W   = $clog2(MAX_HEIGHT + 1);
    // Bytes in one padded row, plus headroom for the rounding add.
    localparam int ROWB_W      = $clog2(3 * MAX_WIDTH + 4);

    // Header byte positions (little-endian 32-bit fields).
    localparam int OFFSET_POS  = 10;
    localparam int WIDTH_POS   = 18;
    localparam int HEIGHT_POS  = 22;
    localparam int HEADER_LAST = 25;

    // Result queue between parser and output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_pixel;
        logic               size_error;
    } t_result;

endpackage

// ----- src/bmpdec_if.sv -----
// Handshake channels of the BMP decoder: byte input and pixel output.
// Depends on bmpdec_pkg for field widths.
interface bmpdec_byte_if;
    import bmpdec_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_file;

    modport source(output valid, data_byte, start_of_file, input ready);
    modport sink(input valid, data_byte, start_of_file, output ready);
endinterface

interface bmpdec_pix_if;
    import bmpdec_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [BYTE_W-1:0]          red;
    logic [BYTE_W-1:0]          green;
    logic [BYTE_W-1:0]          blue;
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row;
    logic signed [SCREEN_W-1:0] screen_y;
    logic                       last_pixel;
    logic                       size_error;

    modport source(output valid, red, green, blue, column, row, screen_y,
                   last_pixel, size_error, input ready);
    modport sink(input valid, red, green, blue, column, row, screen_y,
                 last_pixel, size_error, output ready);
endinterface

// ----- src/bmp_24bit_pixel_stream_decoder_core.sv -----
// Decodes a 24-bit BMP file delivered one byte per item into pixel results.
// The core accepts one byte every clock cycle while the result queue has room;
// a byte whose pixel completes (its red byte) or whose header check fails is pushed
// into the result queue, then the output register. Input ready falls only when the
// four-entry result queue between parser and output stage is full, which
// happens only while the pixel sink stalls. Header bytes 10..13, 18..21 and
// 22..25 give offset, width and height magnitude; bytes up to the offset are
// dropped; rows are padded to four bytes. A width or height above 4096 gives
// one result with size_error set and no pixels. Assert start_of_file on the
// first byte of each file; bottom_line may be written only while idle.
module bmp_24bit_pixel_stream_decoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bmpdec_pkg::COORD_W-1:0] i_cfg_wr_data,
    bmpdec_byte_if.sink                    i_byte,
    bmpdec_pix_if.source                   o_pix
);
    import bmpdec_pkg::*;

    logic    push;
    logic    push_ready;
    t_result push_data;
    logic    pop_valid;
    logic    pop;
    t_result pop_data;

    bmpdec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    bmpdec_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    bmpdec_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pop_valid   (pop_valid),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .o_pix         (o_pix)
    );

endmodule

// ----- src/bmpdec_front.sv -----
// Byte parser: header field capture, skip to pixel data, B,G,R assembly.
// Depends on bmpdec_pkg and bmpdec_byte_if; pushes results into the queue.
module bmpdec_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bmpdec_byte_if.sink          i_byte,
    input  logic                 i_push_ready,
    output logic                 o_push,
    output bmpdec_pkg::t_result  o_push_data
);
    import bmpdec_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]            r_phase, n_phase;
    logic [WORD_W-1:0]     r_pos, n_pos;
    logic [WORD_W-1:0]     r_offset, n_offset;
    logic [WORD_W-1:0]     r_width, n_width;
    logic [23:0]           r_height_lo, n_height_lo;
    logic [ROWB_W-1:0]     r_bir, n_bir;
    logic [1:0]            r_k, n_k;
    logic [COL_CNT_W-1:0]  r_col, n_col;
    logic [ROW_CNT_W-1:0]  r_row, n_row;
    logic [BYTE_W-1:0]     r_blue, n_blue;
    logic [BYTE_W-1:0]     r_green, n_green;
    logic [COL_CNT_W-1:0]  r_wm1, n_wm1;
    logic [ROW_CNT_W-1:0]  r_hm1, n_hm1;
    logic [ROWB_W-1:0]     r_pix_bytes, n_pix_bytes;
    logic [ROWB_W-1:0]     r_row_bytes, n_row_bytes;

    logic                  accept;
    logic [1:0]            phase_e;
    logic [WORD_W-1:0]     pos_e;
    logic [1:0]            lane;
    logic [BYTE_W-1:0]     b;
    logic [WORD_W-1:0]     hgt;
    logic [WORD_W-1:0]     hmag;
    logic [COL_CNT_W-1:0]  w_lo;
    logic [ROWB_W-1:0]     pix_bytes;
    logic [ROWB_W-1:0]     pix_round;
    logic                  do_pixel;
    logic                  last;
    logic                  fin;
    logic [ROWB_W-1:0]     bir_inc;
    t_result               res;

    assign i_byte.ready = i_push_ready;
    assign accept       = i_byte.valid & i_push_ready;
    assign b            = i_byte.data_byte;
    // A start-of-file byte is parsed as byte zero of a fresh header.
    assign phase_e      = i_byte.start_of_file ? PH_HEADER : r_phase;
    assign pos_e        = i_byte.start_of_file ? '0 : r_pos;
    // All three header fields start at byte lane 2 of a 4-byte group.
    assign lane         = pos_e[1:0] - 2'(OFFSET_POS);

    assign hgt       = {b, r_height_lo};
    assign hmag      = b[7] ? (WORD_W'(0) - hgt) : hgt;
    assign w_lo      = r_width[COL_CNT_W-1:0];
    assign pix_bytes = ROWB_W'({w_lo, 1'b0}) + ROWB_W'(w_lo);
    assign pix_round = pix_bytes + ROWB_W'(3);
    assign last      = (r_col == r_wm1) && (r_row == r_hm1);
    assign bir_inc   = r_bir + ROWB_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_offset    = r_offset;
        n_width     = r_width;
        n_height_lo = r_height_lo;
        n_bir       = r_bir;
        n_k         = r_k;
        n_col       = r_col;
        n_row       = r_row;
        n_blue      = r_blue;
        n_green     = r_green;
        n_wm1       = r_wm1;
        n_hm1       = r_hm1;
        n_pix_bytes = r_pix_bytes;
        n_row_bytes = r_row_bytes;
        do_pixel    = 1'b0;
        fin         = 1'b0;
        o_push      = 1'b0;
        res         = '0;

        if (accept) begin
            case (phase_e)
                PH_HEADER: begin
                    n_phase = PH_HEADER;
                    n_pos   = pos_e + WORD_W'(1);
                    if (pos_e inside {[OFFSET_POS:OFFSET_POS+3]}) begin
                        n_offset[{lane, 3'b000} +: BYTE_W] = b;
                    end else if (pos_e inside {[WIDTH_POS:WIDTH_POS+3]}) begin
                        n_width[{lane, 3'b000} +: BYTE_W] = b;
                    end else if (pos_e inside {[HEIGHT_POS:HEADER_LAST-1]}) begin
                        n_height_lo[{lane, 3'b000} +: BYTE_W] = b;
                    end
                    if (pos_e == WORD_W'(HEADER_LAST)) begin
                        n_wm1       = w_lo - COL_CNT_W'(1);
                        n_hm1       = hmag[ROW_CNT_W-1:0] - ROW_CNT_W'(1);
                        n_pix_bytes = pix_bytes;
                        n_row_bytes = {pix_round[ROWB_W-1:2], 2'b00};
                        n_bir       = '0;
                        n_k         = '0;
                        n_col       = '0;
                        n_row       = '0;
                        if (r_width > WORD_W'(MAX_WIDTH) ||
                            hmag > WORD_W'(MAX_HEIGHT)) begin
                            res.size_error = 1'b1;
                            o_push         = 1'b1;
                            n_phase        = PH_DONE;
                        end else if (r_width == '0 || hmag == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_pos < r_offset) begin
                        n_pos = r_pos + WORD_W'(1);
                    end else begin
                        do_pixel = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    do_pixel = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (do_pixel) begin
            n_phase = PH_PIXELS;
            if (r_bir < r_pix_bytes) begin
                case (r_k)
                    2'd0: begin
                        n_blue = b;
                        n_k    = 2'd1;
                    end
                    2'd1: begin
                        n_green = b;
                        n_k     = 2'd2;
                    end
                    default: begin
                        res.red        = b;
                        res.green      = r_green;
                        res.blue       = r_blue;
                        res.column     = r_col[COORD_W-1:0];
                        res.row        = r_row[COORD_W-1:0];
                        res.last_pixel = last;
                        o_push         = 1'b1;
                        n_col          = r_col + COL_CNT_W'(1);
                        n_k            = 2'd0;
                        if (last) begin
                            n_phase = PH_DONE;
                            fin     = 1'b1;
                        end
                    end
                endcase
            end
            if (!fin) begin
                n_bir = bir_inc;
                // Row ends after its padding; advance to the next row.
                if (bir_inc == r_row_bytes) begin
                    n_bir = '0;
                    n_col = '0;
                    n_k   = 2'd0;
                    n_row = r_row + ROW_CNT_W'(1);
                    if (r_row == r_hm1) begin
                        n_phase = PH_DONE;
                    end
                end
            end
        end
    end

    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset    <= n_offset;
        r_width     <= n_width;
        r_height_lo <= n_height_lo;
        r_bir       <= n_bir;
        r_k         <= n_k;
        r_col       <= n_col;
        r_row       <= n_row;
        r_blue      <= n_blue;
        r_green     <= n_green;
        r_wm1       <= n_wm1;
        r_hm1       <= n_hm1;
        r_pix_bytes <= n_pix_bytes;
        r_row_bytes <= n_row_bytes;
    end

endmodule

// ----- src/bmpdec_queue.sv -----
// Small result queue decoupling the byte parser from the output stage.
// Depends on bmpdec_pkg for the result type and depth.
module bmpdec_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bmpdec_pkg::t_result  i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output bmpdec_pkg::t_result  o_pop_data,
    input  logic                 i_pop
);
    import bmpdec_pkg::*;

    t_result            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_push_ready)
        else $error("result pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_pop_valid)
        else $error("result popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr == QPTR_W'(r_rd_ptr + r_count[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

// ----- src/bmpdec_back.sv -----
// Output stage: holds the bottom_line register, forms screen_y, and drives
// the pixel channel from an output register. Depends on bmpdec_pkg, bmpdec_pix_if.
module bmpdec_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bmpdec_pkg::COORD_W-1:0] i_cfg_wr_data,
    input  logic                         i_pop_valid,
    input  bmpdec_pkg::t_result          i_pop_data,
    output logic                         o_pop,
    bmpdec_pix_if.source                 o_pix
);
    import bmpdec_pkg::*;

    localparam logic [COORD_W-1:0] BOTTOM_LINE_RST = COORD_W'(240);

    logic [COORD_W-1:0]  r_bottom_line;
    logic                r_valid;
    t_result             r_res;
    logic [SCREEN_W-1:0] r_screen_y;
    logic [SCREEN_W-1:0] screen_y;
    logic                pop;

    assign pop   = i_pop_valid && (!r_valid || o_pix.ready);
    assign o_pop = pop;
    // Error results carry zero in every field but the error flag.
    assign screen_y = i_pop_data.size_error ? '0 :
                      {1'b0, r_bottom_line} - {1'b0, i_pop_data.row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom_line <= BOTTOM_LINE_RST;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bottom_line <= i_cfg_wr_data;
            end
            if (pop) begin
                r_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res      <= i_pop_data;
            r_screen_y <= screen_y;
        end
    end

    assign o_pix.valid      = r_valid;
    assign o_pix.red        = r_res.red;
    assign o_pix.green      = r_res.green;
    assign o_pix.blue       = r_res.blue;
    assign o_pix.column     = r_res.column;
    assign o_pix.row        = r_res.row;
    assign o_pix.screen_y   = r_screen_y;
    assign o_pix.last_pixel = r_res.last_pixel;
    assign o_pix.size_error = r_res.size_error;

endmodule

// ----- dv/bmp_24bit_pixel_stream_decoder_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bmp_24bit_pixel_stream_decoder_core: streams BMP files byte by
// byte and predicts every pixel and size error. Depends on bmpdec_pkg and bmpdec_if.
module bmp_24bit_pixel_stream_decoder_core_test;
    import bmpdec_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASE_ITEMS    = 240;

    typedef enum logic [1:0] {PARSE_HEADER, PARSE_SKIP, PARSE_PIXELS, PARSE_DONE} t_parse;

    typedef struct packed {
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic [SCREEN_W-1:0] screen_y;
        logic                last_pixel;
        logic                size_error;
    } t_pixel;

    // Tracks the parse of the byte stream and the pixels still owed by the block.
    class bmp_pixel_tracker;
        t_pixel            pixels_due[$];
        bit [COORD_W-1:0]  bottom_line = 12'd240;
        int                mismatches  = 0;
        int                seen        = 0;
        t_parse            parse_state = PARSE_HEADER;
        bit [31:0]         file_pos, data_offset, width, height;
        bit [31:0]         row_byte, col, row;
        bit [7:0]          held_blue, held_green;

        function void restart();
            parse_state = PARSE_HEADER;
            file_pos    = 0;
            data_offset = 0;
            width       = 0;
            height      = 0;
            row_byte    = 0;
            col         = 0;
            row         = 0;
            held_blue   = 0;
            held_green  = 0;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void take_pixel_byte(bit [7:0] b);
            t_pixel    p;
            bit        is_last;
            bit [31:0] row_len;
            if (row_byte < 3 * width) begin
                case (row_byte % 3)
                    0: held_blue = b;
                    1: held_green = b;
                    default: begin
                        is_last      = (col == width - 1) && (row == height - 1);
                        p.red        = b;
                        p.green      = held_green;
                        p.blue       = held_blue;
                        p.column     = col[COORD_W-1:0];
                        p.row        = row[COORD_W-1:0];
                        p.screen_y   = {1'b0, bottom_line} - row[SCREEN_W-1:0];
                        p.last_pixel = is_last;
                        p.size_error = 1'b0;
                        pixels_due.push_back(p);
                        col++;
                        if (is_last) begin
                            parse_state = PARSE_DONE;
                            return;
                        end
                    end
                endcase
            end
            row_len = ((24 * width + 31) / 32) * 4;
            row_byte++;
            if (row_byte >= row_len) begin
                row_byte = 0;
                col      = 0;
                row++;
                if (row >= height)
                    parse_state = PARSE_DONE;
            end
        endfunction

        function void take_byte(bit [7:0] b, bit sof);
            t_pixel    p;
            bit [31:0] pos;
            if (sof)
                restart();
            if (parse_state == PARSE_HEADER) begin
                pos = file_pos;
                if (pos >= OFFSET_POS && pos < OFFSET_POS + 4)
                    data_offset[8 * (pos - OFFSET_POS) +: 8] = b;
                else if (pos >= WIDTH_POS && pos < WIDTH_POS + 4)
                    width[8 * (pos - WIDTH_POS) +: 8] = b;
                else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + 4)
                    height[8 * (pos - HEIGHT_POS) +: 8] = b;
                file_pos++;
                if (pos == HEADER_LAST) begin
                    if (height[31])
                        height = -height;
                    if (width > MAX_WIDTH || height > MAX_HEIGHT) begin
                        p            = '0;
                        p.size_error = 1'b1;
                        pixels_due.push_back(p);
                        parse_state  = PARSE_DONE;
                    end else if (width == 0 || height == 0) begin
                        parse_state = PARSE_DONE;
                    end else begin
                        parse_state = PARSE_SKIP;
                    end
                end
                return;
            end
            if (parse_state == PARSE_SKIP) begin
                if (file_pos < data_offset) begin
                    file_pos++;
                    return;
                end
                parse_state = PARSE_PIXELS;
            end
            if (parse_state == PARSE_PIXELS)
                take_pixel_byte(b);
        endfunction

        task flag(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                     $realtime, seen, what, got, want);
        endtask

        task check_pixel(t_pixel got);
            t_pixel want;
            seen++;
            if (pixels_due.size() == 0) begin
                flag("arrived with nothing pending", 1, 0);
                return;
            end
            want = pixels_due.pop_front();
            if (got.red !== want.red)               flag("red", got.red, want.red);
            if (got.green !== want.green)           flag("green", got.green, want.green);
            if (got.blue !== want.blue)             flag("blue", got.blue, want.blue);
            if (got.column !== want.column)         flag("column", got.column, want.column);
            if (got.row !== want.row)               flag("row", got.row, want.row);
            if (got.screen_y !== want.screen_y)     flag("screen_y", got.screen_y, want.screen_y);
            if (got.last_pixel !== want.last_pixel) flag("last_pixel", got.last_pixel,
                                                         want.last_pixel);
            if (got.size_error !== want.size_error) flag("size_error", got.size_error,
                                                         want.size_error);
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [COORD_W-1:0]  cfg_wr_data;
    bit                  quiet;
    bit                  long_hold;
    int                  items_done;
    bmp_pixel_tracker    chk = new();

    bmpdec_byte_if byte_ch();
    bmpdec_pix_if  pix_ch();

    bmp_24bit_pixel_stream_decoder_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_byte        (byte_ch.sink),
        .o_pix         (pix_ch.source)
    );

    always #4 clk = ~clk;

    // Offer one byte after a random gap and hold it until the block takes it.
    task automatic push_byte(input bit [7:0] b, input bit sof);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        repeat (gap) @(negedge clk) byte_ch.valid = 1'b0;
        @(negedge clk);
        byte_ch.valid         = 1'b1;
        byte_ch.data_byte     = b;
        byte_ch.start_of_file = sof;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        chk.take_byte(b, sof);
    endtask

    task automatic make_bmp(ref bit [7:0] f[$], input bit [31:0] w, input bit [31:0] h,
                            input bit [31:0] off);
        bit [31:0] mag;
        f = {};
        repeat (HEADER_LAST + 1) f.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < 4; k++) begin
            f[OFFSET_POS + k] = off[8 * k +: 8];
            f[WIDTH_POS + k]  = w[8 * k +: 8];
            f[HEIGHT_POS + k] = h[8 * k +: 8];
        end
        mag = h[31] ? -h : h;
        if (w >= 1 && w <= MAX_WIDTH && mag >= 1 && mag <= MAX_HEIGHT) begin
            for (int i = HEADER_LAST + 1; i < off; i++)
                f.push_back(8'($urandom_range(0, 255)));
            repeat (((24 * w + 31) / 32) * 4 * mag) f.push_back(8'($urandom_range(0, 255)));
        end
        // trailing bytes past the image are dropped by the block
        repeat ($urandom_range(0, 3)) f.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_file(ref bit [7:0] f[$], input bit no_gaps);
        quiet = no_gaps;
        for (int i = 0; i < f.size(); i++)
            push_byte(f[i], i == 0);
    endtask

    task automatic write_bottom_line(input bit [COORD_W-1:0] v);
        @(negedge clk) byte_ch.valid = 1'b0;
        while (chk.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk) cfg_wr_en = 1'b0;
        chk.bottom_line = v;
    endtask

    task automatic directed_files();
        bit [7:0] f[$];
        // one pixel, offset inside the header, extreme byte values
        make_bmp(f, 1, 1, 0);
        f[26] = 8'h00;
        f[27] = 8'hFF;
        f[28] = 8'hA5;
        send_file(f, 0);
        make_bmp(f, 3, -2, 54);
        send_file(f, 0);
        // rows without padding
        make_bmp(f, 4, 2, 26);
        send_file(f, 1);
        make_bmp(f, 4097, 1, 0);
        send_file(f, 0);
        make_bmp(f, 2, -4097, 0);
        send_file(f, 0);
        make_bmp(f, 32'hFFFF_FFFF, 1, 30);
        send_file(f, 0);
        make_bmp(f, 5, 32'h8000_0000, 0);
        send_file(f, 0);
        make_bmp(f, 0, 3, 0);
        send_file(f, 0);
        make_bmp(f, 3, 0, 0);
        send_file(f, 0);
        // cut inside the pixel data, then inside the header
        make_bmp(f, 2, 2, 40);
        f = f[0:45];
        send_file(f, 0);
        make_bmp(f, 2, 1, 0);
        f = f[0:15];
        send_file(f, 0);
        make_bmp(f, 2, 3, 27);
        repeat (6) f.push_back(8'($urandom_range(0, 255)));
        send_file(f, 0);
    endtask

    task automatic random_file();
        bit [7:0]  f[$];
        bit [31:0] w, h, off;
        int        kind;
        kind = $urandom_range(0, 99);
        w    = $urandom_range(1, 9);
        h    = $urandom_range(1, 5);
        if ($urandom_range(0, 1))
            h = -h;
        off  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 26) : $urandom_range(27, 70);
        if (kind >= 90) begin
            // noise with the odd restart mixed in
            quiet = 1'b0;
            repeat ($urandom_range(1, 16))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            return;
        end
        if (kind >= 80 && kind < 86) begin
            case ($urandom_range(0, 3))
                0: w = $urandom_range(MAX_WIDTH + 1, 70000);
                1: w = $urandom;
                2: h = -$urandom_range(MAX_HEIGHT + 1, 100000);
                default: h = $urandom_range(MAX_HEIGHT + 1, 32'h7FFF_FFFF);
            endcase
        end else if (kind >= 86) begin
            if ($urandom_range(0, 1))
                w = 0;
            else
                h = 0;
        end
        make_bmp(f, w, h, off);
        if (kind >= 72 && kind < 80)
            f = f[0:$urandom_range(0, f.size() - 2)];
        send_file(f, $urandom_range(0, 4) == 0);
        items_done += f.size();
    endtask

    task automatic random_phase();
        int target;
        target = items_done + PHASE_ITEMS;
        while (items_done < target)
            random_file();
    endtask

    initial begin : byte_source
        bit [7:0] f[$];
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = '0;
        byte_ch.start_of_file = 1'b0;
        quiet                 = 1'b0;
        long_hold             = 1'b0;
        items_done            = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        directed_files();
        write_bottom_line(12'd4095);
        random_phase();
        write_bottom_line(COORD_W'($urandom_range(0, 4095)));
        random_phase();
        write_bottom_line(12'd0);
        random_phase();
        // largest sizes, cut short and sent back to back; the sink stalls during the wide one
        long_hold = 1'b1;
        make_bmp(f, MAX_WIDTH, 1, 0);
        f = f[0:HEADER_LAST + 120];
        send_file(f, 1);
        make_bmp(f, 1, -MAX_HEIGHT, 54);
        f = f[0:53 + 40];
        send_file(f, 1);

        @(negedge clk) byte_ch.valid = 1'b0;
        while (chk.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (chk.mismatches == 0)
            $display("bmp_24bit_pixel_stream_decoder_core regression: pass");
        else
            $display("bmp_24bit_pixel_stream_decoder_core regression: fail");
        $finish;
    end

    initial begin : pixel_sink
        t_pixel got;
        int     stall;
        pix_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (chk.seen == 150 || long_hold) begin
                long_hold = 1'b0;
                stall     = HOLD_CYCLES;
            end
            repeat (stall) @(negedge clk) pix_ch.ready = 1'b0;
            @(negedge clk) pix_ch.ready = 1'b1;
            @(posedge clk);
            while (!pix_ch.valid) @(posedge clk);
            got.red        = pix_ch.red;
            got.green      = pix_ch.green;
            got.blue       = pix_ch.blue;
            got.column     = pix_ch.column;
            got.row        = pix_ch.row;
            got.screen_y   = pix_ch.screen_y;
            got.last_pixel = pix_ch.last_pixel;
            got.size_error = pix_ch.size_error;
            chk.check_pixel(got);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("bmp_24bit_pixel_stream_decoder_core regression: fail");
                $finish;
            end
        end
    end

endmodule
